@@ sv/quadratic_root_solver_defines.svh @@
// Assertion helpers for the solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define QRS_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define QRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/qrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

    // root_status codes
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_DOUBLE = 2'd1;
    localparam logic [1:0] ST_TWO    = 2'd2;
    localparam logic [1:0] ST_DEGEN  = 2'd3;

    // Q8.8 squared gives 16 fraction bits; sqrt then yields 8 more.
    localparam int FRAC_SHIFT = 16;
    localparam int Q_SHIFT    = 8;

    // Per-word classification carried down the cell chains.
    typedef struct packed {
        logic deg;    // leading coefficient zero
        logic dneg;   // discriminant negative
        logic dzero;  // discriminant zero
    } qrs_ctl_t;

endpackage

`default_nettype wire

@@ sv/quadratic_root_solver.sv @@
// Real roots of a*x^2 + b*x + c, coefficients signed Q8.8, roots signed Q16.16.
// Input channel: s_valid/s_ready with s_coef_a, s_coef_b, s_coef_c, one word per
// polynomial. Result channel: m_valid/m_ready with m_root_status (none, double,
// two, degenerate), m_first_root (+sqrt), m_second_root (-sqrt) and
// m_root_saturated. Exactly one result word leaves for each input word, in order.
// The pipeline holds two front stages (products, discriminant), COEF_WIDTH+9
// square-root cells, a numerator stage, COEF_WIDTH+19 divider cells and the
// output register.
// Throughput: one word per cycle; every cell holds one word and hands it on.
// Each cell is ready when it is empty or its successor is ready, so a stalled
// receiver holds the words in place while bubbles ahead of the stall still fill;
// input is refused only once every stage up to the output holds a word.
// Reset (aresetn low, synchronous) empties every stage; no word is in flight
// afterward and m_valid is low.
`timescale 1ns / 1ps
`default_nettype none

`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver #(
    parameter int COEF_WIDTH = 16,
    parameter int ROOT_WIDTH = 32
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  signed [COEF_WIDTH-1:0] s_coef_a,
    input  wire  signed [COEF_WIDTH-1:0] s_coef_b,
    input  wire  signed [COEF_WIDTH-1:0] s_coef_c,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [1:0]                   m_root_status,
    output logic signed [ROOT_WIDTH-1:0] m_first_root,
    output logic signed [ROOT_WIDTH-1:0] m_second_root,
    output logic                         m_root_saturated
);
    import qrs_pkg::*;

    localparam int W      = COEF_WIDTH;
    localparam int RW     = ROOT_WIDTH;
    localparam int DW     = 2 * W + 3;          // signed discriminant
    localparam int RAD_W  = 2 * W + 18;         // radicand, even width
    localparam int SQ_W   = RAD_W / 2;          // root width = number of sqrt cells
    localparam int NW     = W + 11;             // signed numerator before scaling
    localparam int QW     = W + 19;             // dividend / quotient width
    localparam int DEN_W  = W + 1;
    localparam int SIDE_SQ = 2 * W;
    localparam int CMPW   = ((QW > RW) ? QW : RW) + 1;

    // ---------------- stage 1: products ----------------
    logic                   v1_reg, rdy1, rdy2;
    logic signed [W-1:0]    a1_reg, b1_reg;
    logic signed [2*W-1:0]  bb1_reg, ac1_reg;
    logic                   deg1_reg;

    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            a1_reg   <= s_coef_a;
            b1_reg   <= s_coef_b;
            bb1_reg  <= s_coef_b * s_coef_b;
            ac1_reg  <= s_coef_a * s_coef_c;
            deg1_reg <= (s_coef_a == '0);
        end
    end

    // ---------------- stage 2: discriminant ----------------
    logic                   v2_reg;
    logic signed [DW-1:0]   bb_x, ac_x, disc;
    logic [RAD_W-1:0]       rad2_reg;
    qrs_ctl_t               ctl2_reg;
    logic [SIDE_SQ-1:0]     side2_reg;

    logic                   sq_v   [0:SQ_W];
    logic                   sq_rdy [0:SQ_W];
    qrs_ctl_t               sq_ctl [0:SQ_W];
    logic [RAD_W-1:0]       sq_rad [0:SQ_W];
    logic [SQ_W+1:0]        sq_rem [0:SQ_W];
    logic [SQ_W-1:0]        sq_root[0:SQ_W];
    logic [SIDE_SQ-1:0]     sq_side[0:SQ_W];

    assign bb_x = DW'(bb1_reg);
    assign ac_x = DW'(ac1_reg);
    assign disc = bb_x - (ac_x <<< 2);
    assign rdy2 = !v2_reg || sq_rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            // Drop negative discriminants to a zero radicand; their roots are unused.
            rad2_reg <= disc[DW-1] ? '0 : {1'b0, disc[2*W:0], {FRAC_SHIFT{1'b0}}};
            ctl2_reg <= '{deg: deg1_reg, dneg: disc[DW-1], dzero: (disc == '0)};
            side2_reg <= {a1_reg, b1_reg};
        end
    end

    // ---------------- square-root chain ----------------
    assign sq_v[0]    = v2_reg;
    assign sq_ctl[0]  = ctl2_reg;
    assign sq_rad[0]  = rad2_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = side2_reg;

    for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
        qrs_sqrt_cell #(
            .ROOT_W (SQ_W),
            .RAD_W  (RAD_W),
            .SIDE_W (SIDE_SQ)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_v[k]),
            .in_ready  (sq_rdy[k]),
            .in_ctl    (sq_ctl[k]),
            .in_rad    (sq_rad[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .in_side   (sq_side[k]),
            .out_valid (sq_v[k+1]),
            .out_ready (sq_rdy[k+1]),
            .out_ctl   (sq_ctl[k+1]),
            .out_rad   (sq_rad[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1]),
            .out_side  (sq_side[k+1])
        );
    end

    // ---------------- stage 3: numerators and divisor ----------------
    logic                   v3_reg;
    logic signed [W-1:0]    a3, b3;
    logic signed [NW-1:0]   nb, sroot, n1, n2;
    logic [NW-1:0]          m1, m2;
    logic [W-1:0]           amag;
    logic [QW-1:0]          x1_3_reg, x2_3_reg;
    logic [DEN_W-1:0]       den3_reg;
    logic [1:0]             neg3_reg;
    qrs_ctl_t               ctl3_reg;

    logic                   dv_v   [0:QW];
    logic                   dv_rdy [0:QW];
    qrs_ctl_t               dv_ctl [0:QW];
    logic [DEN_W-1:0]       dv_den [0:QW];
    logic [DEN_W-1:0]       dv_rem1[0:QW];
    logic [QW-1:0]          dv_x1  [0:QW];
    logic [DEN_W-1:0]       dv_rem2[0:QW];
    logic [QW-1:0]          dv_x2  [0:QW];
    logic [1:0]             dv_side[0:QW];

    always_comb begin
        {a3, b3} = sq_side[SQ_W];
        nb    = -(NW'(b3) <<< Q_SHIFT);
        sroot = NW'({2'b00, sq_root[SQ_W]});
        n1    = nb + sroot;
        n2    = nb - sroot;
        m1    = n1[NW-1] ? NW'(-n1) : NW'(n1);
        m2    = n2[NW-1] ? NW'(-n2) : NW'(n2);
        amag  = a3[W-1] ? W'(-a3) : W'(a3);
    end

    assign sq_rdy[SQ_W] = !v3_reg || dv_rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (sq_rdy[SQ_W]) begin
            v3_reg <= sq_v[SQ_W];
        end
    end

    // Dividend carries |N|*256 plus half the divisor for round-half-away.
    always_ff @(posedge aclk) begin
        if (sq_rdy[SQ_W] && sq_v[SQ_W]) begin
            x1_3_reg <= QW'({m1[NW-2:0], {Q_SHIFT{1'b0}}}) + QW'(amag);
            x2_3_reg <= QW'({m2[NW-2:0], {Q_SHIFT{1'b0}}}) + QW'(amag);
            den3_reg <= {amag, 1'b0};
            neg3_reg <= {n1[NW-1] ^ a3[W-1], n2[NW-1] ^ a3[W-1]};
            ctl3_reg <= sq_ctl[SQ_W];
        end
    end

    // ---------------- divider chain ----------------
    assign dv_v[0]    = v3_reg;
    assign dv_ctl[0]  = ctl3_reg;
    assign dv_den[0]  = den3_reg;
    assign dv_rem1[0] = '0;
    assign dv_x1[0]   = x1_3_reg;
    assign dv_rem2[0] = '0;
    assign dv_x2[0]   = x2_3_reg;
    assign dv_side[0] = neg3_reg;

    for (genvar k = 0; k < QW; k++) begin : g_div
        qrs_div_cell #(
            .DEN_W  (DEN_W),
            .Q_W    (QW),
            .SIDE_W (2)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (dv_v[k]),
            .in_ready  (dv_rdy[k]),
            .in_ctl    (dv_ctl[k]),
            .in_den    (dv_den[k]),
            .in_rem1   (dv_rem1[k]),
            .in_x1     (dv_x1[k]),
            .in_rem2   (dv_rem2[k]),
            .in_x2     (dv_x2[k]),
            .in_side   (dv_side[k]),
            .out_valid (dv_v[k+1]),
            .out_ready (dv_rdy[k+1]),
            .out_ctl   (dv_ctl[k+1]),
            .out_den   (dv_den[k+1]),
            .out_rem1  (dv_rem1[k+1]),
            .out_x1    (dv_x1[k+1]),
            .out_rem2  (dv_rem2[k+1]),
            .out_x2    (dv_x2[k+1]),
            .out_side  (dv_side[k+1])
        );
    end

    // ---------------- output register: sign, saturate, status ----------------
    // Returns {clipped, signed root}.
    function automatic logic [RW:0] sat_root(input logic [QW-1:0] uq, input logic neg);
        logic [CMPW-1:0] u, lim, mag;
        logic            clip;
        u   = CMPW'(uq);
        lim = CMPW'(1) << (RW - 1);
        if (neg) begin
            clip = (u > lim);
            mag  = clip ? lim : u;
            return {clip, RW'(-mag)};
        end else begin
            clip = (u > lim - CMPW'(1));
            mag  = clip ? lim - CMPW'(1) : u;
            return {clip, RW'(mag)};
        end
    endfunction

    logic                 out_rdy;
    logic                 m_valid_reg, sat_reg;
    logic [1:0]           status_reg;
    logic [RW-1:0]        root1_reg, root2_reg;
    logic [RW:0]          r1, r2;
    qrs_ctl_t             ctl_f;

    assign ctl_f   = dv_ctl[QW];
    assign r1      = sat_root(dv_x1[QW], dv_side[QW][1]);
    assign r2      = sat_root(dv_x2[QW], dv_side[QW][0]);
    assign out_rdy = !m_valid_reg || m_ready;
    assign dv_rdy[QW] = out_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_rdy) begin
            m_valid_reg <= dv_v[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy && dv_v[QW]) begin
            if (ctl_f.deg) begin
                status_reg <= ST_DEGEN;
                root1_reg  <= '0;
                root2_reg  <= '0;
                sat_reg    <= 1'b0;
            end else if (ctl_f.dneg) begin
                status_reg <= ST_NONE;
                root1_reg  <= '0;
                root2_reg  <= '0;
                sat_reg    <= 1'b0;
            end else begin
                status_reg <= ctl_f.dzero ? ST_DOUBLE : ST_TWO;
                root1_reg  <= r1[RW-1:0];
                root2_reg  <= r2[RW-1:0];
                sat_reg    <= r1[RW] | r2[RW];
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_root_status    = status_reg;
    assign m_first_root     = root1_reg;
    assign m_second_root    = root2_reg;
    assign m_root_saturated = sat_reg;

    // ---------------- checks ----------------
    `QRS_ASSERT_IMPLY(a_double_equal, aclk, aresetn, m_valid && (m_root_status == ST_DOUBLE), m_first_root == m_second_root, "double root fields differ")
    `QRS_ASSERT_IMPLY(a_noroot_clear, aclk, aresetn, m_valid && ((m_root_status == ST_NONE) || (m_root_status == ST_DEGEN)), (m_first_root == '0) && (m_second_root == '0) && !m_root_saturated, "root fields not cleared")
    `QRS_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_root_status) && $stable(m_first_root) && $stable(m_second_root) && $stable(m_root_saturated), "result word changed while stalled")
    `QRS_ASSERT_NEXT(a_drain, aclk, aresetn, dv_v[QW] && out_rdy, m_valid, "divider word lost at output")

endmodule

`default_nettype wire

@@ sv/qrs_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One digit of a restoring square root: two radicand bits in, one root bit out.
module qrs_sqrt_cell #(
    parameter int ROOT_W = 25,
    parameter int RAD_W  = 50,
    parameter int SIDE_W = 32
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  qrs_pkg::qrs_ctl_t      in_ctl,
    input  wire  [RAD_W-1:0]       in_rad,
    input  wire  [ROOT_W+1:0]      in_rem,
    input  wire  [ROOT_W-1:0]      in_root,
    input  wire  [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    input  wire                    out_ready,
    output qrs_pkg::qrs_ctl_t      out_ctl,
    output logic [RAD_W-1:0]       out_rad,
    output logic [ROOT_W+1:0]      out_rem,
    output logic [ROOT_W-1:0]      out_root,
    output logic [SIDE_W-1:0]      out_side
);
    import qrs_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic             valid_reg;
    qrs_ctl_t         ctl_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SIDE_W-1:0] side_reg;
    logic [REM_W+1:0] cand, trial;
    logic             take;

    always_comb begin
        cand      = {in_rem, in_rad[RAD_W-1 -: 2]};
        trial     = {2'b00, in_root, 2'b01};
        take      = (cand >= trial);
        rem_next  = take ? REM_W'(cand - trial) : REM_W'(cand);
        root_next = {in_root[ROOT_W-2:0], take};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg  <= in_ctl;
            rad_reg  <= {in_rad[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

@@ sv/qrs_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One quotient bit of a restoring division, two lanes sharing one divisor.
module qrs_div_cell #(
    parameter int DEN_W  = 17,
    parameter int Q_W    = 35,
    parameter int SIDE_W = 2
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  qrs_pkg::qrs_ctl_t     in_ctl,
    input  wire  [DEN_W-1:0]      in_den,
    input  wire  [DEN_W-1:0]      in_rem1,
    input  wire  [Q_W-1:0]        in_x1,
    input  wire  [DEN_W-1:0]      in_rem2,
    input  wire  [Q_W-1:0]        in_x2,
    input  wire  [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    input  wire                   out_ready,
    output qrs_pkg::qrs_ctl_t     out_ctl,
    output logic [DEN_W-1:0]      out_den,
    output logic [DEN_W-1:0]      out_rem1,
    output logic [Q_W-1:0]        out_x1,
    output logic [DEN_W-1:0]      out_rem2,
    output logic [Q_W-1:0]        out_x2,
    output logic [SIDE_W-1:0]     out_side
);
    import qrs_pkg::*;

    // Returns {new remainder, shifted dividend with the quotient bit in}.
    function automatic logic [DEN_W+Q_W-1:0] step(input logic [DEN_W-1:0] rem,
                                                  input logic [Q_W-1:0]   x,
                                                  input logic [DEN_W-1:0] den);
        logic [DEN_W:0]   cand;
        logic             take;
        logic [DEN_W-1:0] r;
        cand = {rem, x[Q_W-1]};
        take = (cand >= {1'b0, den});
        r    = take ? DEN_W'(cand - {1'b0, den}) : DEN_W'(cand);
        return {r, x[Q_W-2:0], take};
    endfunction

    logic                   valid_reg;
    qrs_ctl_t               ctl_reg;
    logic [DEN_W-1:0]       den_reg, rem1_reg, rem2_reg;
    logic [Q_W-1:0]         x1_reg, x2_reg;
    logic [SIDE_W-1:0]      side_reg;
    logic [DEN_W+Q_W-1:0]   lane1_next, lane2_next;

    assign lane1_next = step(in_rem1, in_x1, in_den);
    assign lane2_next = step(in_rem2, in_x2, in_den);
    assign in_ready   = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg  <= in_ctl;
            den_reg  <= in_den;
            {rem1_reg, x1_reg} <= lane1_next;
            {rem2_reg, x2_reg} <= lane2_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_den   = den_reg;
    assign out_rem1  = rem1_reg;
    assign out_x1    = x1_reg;
    assign out_rem2  = rem2_reg;
    assign out_x2    = x2_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

@@ tb/quadratic_root_solver_tb.sv @@
`timescale 1ns / 1ps

module quadratic_root_solver_tb;
    import qrs_pkg::*;

    localparam int CW = 16;
    localparam int RW = 32;
    localparam int LATENCY = 2 * CW + 32;
    localparam int RANDOM_WORDS = 1750;

    typedef struct {
        logic [1:0]           status;
        logic signed [RW-1:0] first;
        logic signed [RW-1:0] second;
        logic                 sat;
    } roots_t;

    typedef struct {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        bit                   typed;   // expected result typed in below
        roots_t               want;
    } coef_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [CW-1:0] s_coef_a = '0;
    logic signed [CW-1:0] s_coef_b = '0;
    logic signed [CW-1:0] s_coef_c = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_root_status;
    logic signed [RW-1:0] m_first_root;
    logic signed [RW-1:0] m_second_root;
    logic                 m_root_saturated;

    roots_t    pending_roots[$];
    coef_row_t directed[16];
    int        mismatches = 0;
    int        words_sent = 0;
    int        words_seen = 0;
    int        clipped_seen = 0;
    int        status_seen[4] = '{0, 0, 0, 0};
    bit        no_stall = 1'b0;

    quadratic_root_solver #(.COEF_WIDTH(CW), .ROOT_WIDTH(RW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coef_a(s_coef_a), .s_coef_b(s_coef_b), .s_coef_c(s_coef_c),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_root_status(m_root_status), .m_first_root(m_first_root),
        .m_second_root(m_second_root), .m_root_saturated(m_root_saturated)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bitwise integer square root, truncated.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned probe;
        res = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v -= res + probe;
                res = (res >> 1) + probe;
            end else begin
                res >>= 1;
            end
            probe >>= 2;
        end
        return res;
    endfunction

    // Round num/den to nearest, ties away from zero, then clip to RW bits.
    // Return {clipped, value}.
    function automatic logic [RW:0] rounded_root(longint num, longint den);
        longint unsigned un, ud, uq, hi;
        bit neg;
        bit clip;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        uq = (un + ud / 2) / ud;
        neg = (num < 0) != (den < 0);
        hi = (64'd1 << (RW - 1)) - 1;
        clip = 1'b0;
        if (neg) begin
            if (uq > hi + 1) begin
                uq = hi + 1;
                clip = 1'b1;
            end
            uq = -uq;
        end else if (uq > hi) begin
            uq = hi;
            clip = 1'b1;
        end
        return {clip, uq[RW-1:0]};
    endfunction

    function automatic roots_t solve_quadratic(logic signed [CW-1:0] ca,
                                               logic signed [CW-1:0] cb,
                                               logic signed [CW-1:0] cc);
        roots_t r;
        longint a, b, c, disc, sq;
        logic [RW:0] r1, r2;
        a = ca;
        b = cb;
        c = cc;
        r = '{ST_NONE, '0, '0, 1'b0};
        if (a == 0) begin
            r.status = ST_DEGEN;
            return r;
        end
        disc = b * b - 4 * a * c;
        if (disc < 0) return r;
        sq = int_sqrt(disc << FRAC_SHIFT);
        r1 = rounded_root((-b * 256 + sq) * 256, 2 * a);
        r2 = rounded_root((-b * 256 - sq) * 256, 2 * a);
        r.status = (disc == 0) ? ST_DOUBLE : ST_TWO;
        r.first = r1[RW-1:0];
        r.second = r2[RW-1:0];
        r.sat = r1[RW] | r2[RW];
        return r;
    endfunction

    // Gap length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Pick a coefficient biased toward extremes, zero and tiny values.
    function automatic logic signed [CW-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(0, 6)) - 3);
            default: return CW'($urandom());
        endcase
    endfunction

    // Hold the word until accepted, then queue its expected roots.
    task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                              logic signed [CW-1:0] c, bit typed, roots_t want);
        int gap;
        s_valid <= 1'b1;
        s_coef_a <= a;
        s_coef_b <= b;
        s_coef_c <= c;
        do @(posedge aclk); while (!s_ready);
        pending_roots.push_back(typed ? want : solve_quadratic(a, b, c));
        words_sent++;
        gap = no_stall ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Receiver back-pressure: alternate ready and stalled stretches.
    int ready_left = 0;
    always @(posedge aclk) begin
        if (no_stall) begin
            m_ready <= 1'b1;
        end else if (ready_left == 0) begin
            if (!m_ready) begin
                m_ready <= 1'b1;
                ready_left <= $urandom_range(1, 20);
            end else begin
                m_ready <= 1'b0;
                ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 3);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        roots_t want;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (pending_roots.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d", m_root_status);
            end else begin
                want = pending_roots.pop_front();
                status_seen[m_root_status]++;
                if (m_root_saturated) clipped_seen++;
                if (m_root_status !== want.status || m_first_root !== want.first ||
                    m_second_root !== want.second || m_root_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch word %0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 words_seen, want.status, want.first, want.second,
                                 want.sat, m_root_status, m_first_root,
                                 m_second_root, m_root_saturated);
                end
            end
        end
    end

    // Watchdog: end a hung run.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        roots_t nil;
        int wait_cycles;
        nil = '{ST_NONE, '0, '0, 1'b0};
        // Directed rows; typed ones carry their expected roots.
        directed[0]  = '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{ST_DEGEN, '0, '0, 1'b0}};
        directed[1]  = '{16'sd0, 16'sh7fff, 16'sh8000, 1'b1, '{ST_DEGEN, '0, '0, 1'b0}};
        directed[2]  = '{16'sd256, 16'sd0, 16'sd256, 1'b1, nil};
        directed[3]  = '{16'sd256, 16'sd0, 16'sd0, 1'b1, '{ST_DOUBLE, '0, '0, 1'b0}};
        directed[4]  = '{16'sd256, -16'sd512, 16'sd256, 1'b1,
                         '{ST_DOUBLE, 32'sd65536, 32'sd65536, 1'b0}};
        directed[5]  = '{16'sd256, 16'sd0, -16'sd256, 1'b1,
                         '{ST_TWO, 32'sd65536, -32'sd65536, 1'b0}};
        directed[6]  = '{16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, nil};
        directed[7]  = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, nil};
        directed[8]  = '{16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, nil};
        directed[9]  = '{16'sd1, 16'sh8000, 16'sd0, 1'b0, nil};
        directed[10] = '{16'sd1, 16'sh7fff, 16'sd0, 1'b0, nil};
        directed[11] = '{-16'sd1, 16'sh8000, 16'sh7fff, 1'b0, nil};
        directed[12] = '{-16'sd256, 16'sd0, 16'sd256, 1'b0, nil};
        directed[13] = '{16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, nil};
        directed[14] = '{16'sh8000, 16'sd0, 16'sh7fff, 1'b0, nil};
        directed[15] = '{16'sd1, 16'sd1, 16'sd0, 1'b0, nil};

        // Hold reset low at the start, then release it for good.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i])
            send_coefs(directed[i].a, directed[i].b, directed[i].c,
                       directed[i].typed, directed[i].want);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            logic signed [CW-1:0] a, b, c;
            // Run one stretch flat out with no idling on either side.
            no_stall = (n >= 800 && n < 900);
            a = ($urandom_range(0, 19) == 0) ? 16'sd0 : pick_coef();
            b = pick_coef();
            c = pick_coef();
            send_coefs(a, b, c, 1'b0, nil);
        end
        no_stall = 1'b0;
        s_valid <= 1'b0;

        // Drain: wait for every expected word, then let the pipe settle.
        wait_cycles = 0;
        while (pending_roots.size() != 0 && wait_cycles < 200_000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (2 * LATENCY) @(posedge aclk);

        $display("sent %0d coefficient words, checked %0d results", words_sent, words_seen);
        $display("none %0d, double %0d, two %0d, degenerate %0d, clipped %0d",
                 status_seen[ST_NONE], status_seen[ST_DOUBLE], status_seen[ST_TWO],
                 status_seen[ST_DEGEN], clipped_seen);
        if (mismatches == 0 && pending_roots.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_roots.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
